/* src/pep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pep_pkg;

    // channel and register widths
    localparam int CH_W     = 6;
    localparam int BRIGHT_W = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CH_W-1:0]     CH_MAX      = 6'd63;
    localparam logic [7:0]          ALPHA_BYTE  = 8'hff;
    localparam logic [BRIGHT_W-1:0] BRIGHT_ONE  = 17'd65536;
    localparam logic [21:0]         BRIGHT_HALF = 22'd32768;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUM_MASK     = 3'd0,
        REG_HEALTH_LEVEL = 3'd1,
        REG_SHIELD_LEVEL = 3'd2,
        REG_FLASH_LEVEL  = 3'd3,
        REG_FX_ENABLE    = 3'd4,
        REG_BRIGHTNESS   = 3'd5,
        REG_BRIGHT_EN    = 3'd6
    } cfg_idx_t;

    // one palette entry in flight
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // configuration seen by the stages
    typedef struct packed {
        logic [2:0]          lum_mask;
        logic [CH_W-1:0]     health_level;
        logic [CH_W-1:0]     shield_level;
        logic [CH_W-1:0]     flash_level;
        logic                fx_enable;
        logic [BRIGHT_W-1:0] brightness;
        logic                bright_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        lum_mask:      3'd0,
        health_level:  6'd0,
        shield_level:  6'd0,
        flash_level:   6'd0,
        fx_enable:     1'b1,
        brightness:    BRIGHT_ONE,
        bright_enable: 1'b1
    };

    // 6-bit channel to 8-bit by bit replication
    function automatic logic [7:0] widen6(input logic [CH_W-1:0] x);
        widen6 = {x, x[5:4]};
    endfunction

endpackage

`default_nettype wire

/* src/palette_effect_pipeline.sv */
// channel | signals                              | direction | transaction
// input   | in_valid, in_ready, red, green, blue | in        | one palette entry
// output  | out_valid, out_ready, argb           | out       | one packed color
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in   | one register write
//
// one entry per cycle sustained while the output does not stall; four register
// stages (luminance, tint, brightness, pack) that a result passes through in order
// reset clears every stage valid bit and loads the register defaults
// a stall at the output holds each full stage; empty stages keep filling
// config writes are always taken; cfg_ready is tied high
`timescale 1ns / 1ps
`default_nettype none

module palette_effect_pipeline (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [5:0]  red,
    input  wire logic [5:0]  green,
    input  wire logic [5:0]  blue,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      argb,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    pep_pkg::cfg_t cfg_reg;
    pep_pkg::rgb_t in_data;
    pep_pkg::rgb_t lum_data;
    pep_pkg::rgb_t tint_data;
    pep_pkg::rgb_t bright_data;
    logic          lum_valid;
    logic          lum_ready;
    logic          tint_valid;
    logic          tint_ready;
    logic          bright_valid;
    logic          bright_ready;
    logic          out_valid_reg;
    logic [31:0]   argb_reg;
    logic [31:0]   argb_next;

    assign cfg_ready = 1'b1;
    assign in_data   = '{r: red, g: green, b: blue};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= pep_pkg::CFG_RESET;
        else if (cfg_valid)
        begin
            case (cfg_index)
                pep_pkg::REG_LUM_MASK:     cfg_reg.lum_mask      <= cfg_data[2:0];
                pep_pkg::REG_HEALTH_LEVEL: cfg_reg.health_level  <= cfg_data[5:0];
                pep_pkg::REG_SHIELD_LEVEL: cfg_reg.shield_level  <= cfg_data[5:0];
                pep_pkg::REG_FLASH_LEVEL:  cfg_reg.flash_level   <= cfg_data[5:0];
                pep_pkg::REG_FX_ENABLE:    cfg_reg.fx_enable     <= cfg_data[0];
                pep_pkg::REG_BRIGHTNESS:   cfg_reg.brightness    <= cfg_data;
                pep_pkg::REG_BRIGHT_EN:    cfg_reg.bright_enable <= cfg_data[0];
                default:                   cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // luminance stage
    pep_lum u_lum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .up_data    (in_data),
        .down_valid (lum_valid),
        .down_ready (lum_ready),
        .down_data  (lum_data)
    );

    // tint stage
    pep_tint u_tint (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (lum_valid),
        .up_ready   (lum_ready),
        .up_data    (lum_data),
        .down_valid (tint_valid),
        .down_ready (tint_ready),
        .down_data  (tint_data)
    );

    // brightness stage
    pep_bright u_bright (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (tint_valid),
        .up_ready   (tint_ready),
        .up_data    (tint_data),
        .down_valid (bright_valid),
        .down_ready (bright_ready),
        .down_data  (bright_data)
    );

    // pack stage: widen channels and add alpha
    assign bright_ready = !out_valid_reg || out_ready;
    assign argb_next    = {pep_pkg::ALPHA_BYTE, pep_pkg::widen6(bright_data.b),
                           pep_pkg::widen6(bright_data.g), pep_pkg::widen6(bright_data.r)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (bright_ready)
            out_valid_reg <= bright_valid;
    end

    always_ff @(posedge clk)
    begin
        if (bright_valid && bright_ready)
            argb_reg <= argb_next;
    end

    assign out_valid = out_valid_reg;
    assign argb      = argb_reg;

    // a taken result frees every stage back to the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> in_ready)
        else $error("input not ready while output drains");

    // alpha byte is constant on every result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (argb[31:24] == pep_pkg::ALPHA_BYTE))
        else $error("alpha byte wrong");

    // widened channels repeat their top bits in the low bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((argb[1:0] == argb[7:6]) && (argb[9:8] == argb[15:14])
                       && (argb[17:16] == argb[23:22])))
        else $error("channel widening inconsistent");

endmodule

`default_nettype wire

/* src/pep_lum.sv */
`timescale 1ns / 1ps
`default_nettype none

module pep_lum (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pep_pkg::cfg_t cfg,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire pep_pkg::rgb_t up_data,
    output logic              down_valid,
    input  wire logic         down_ready,
    output pep_pkg::rgb_t     down_data
);

    logic          valid_reg;
    pep_pkg::rgb_t data_reg;
    pep_pkg::rgb_t data_next;
    logic [6:0]    lum_sum;

    // stage advances when empty or when the next stage takes its transaction
    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // luminance to masked channels, others cleared; a zero mask passes the entry through
    always_comb
    begin
        lum_sum   = 7'({2'd0, up_data.r[5:2]}) + 7'({1'b0, up_data.g[5:1]})
                  + 7'({2'd0, up_data.b[5:2]});
        data_next = up_data;
        if (cfg.lum_mask != 3'd0)
        begin
            data_next.r = cfg.lum_mask[0] ? lum_sum[5:0] : 6'd0;
            data_next.g = cfg.lum_mask[1] ? lum_sum[5:0] : 6'd0;
            data_next.b = cfg.lum_mask[2] ? lum_sum[5:0] : 6'd0;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

/* src/pep_tint.sv */
`timescale 1ns / 1ps
`default_nettype none

module pep_tint (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pep_pkg::cfg_t cfg,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire pep_pkg::rgb_t up_data,
    output logic              down_valid,
    input  wire logic         down_ready,
    output pep_pkg::rgb_t     down_data
);

    // scale a channel by intensity/64, or push the filter channel toward full
    function automatic logic [5:0] tint_ch(input logic [5:0] c,
                                           input logic [5:0] inten,
                                           input logic       filt);
        logic [11:0] prod;
        begin
            if (filt)
            begin
                prod    = 12'(pep_pkg::CH_MAX - c) * 12'(inten);
                tint_ch = pep_pkg::CH_MAX - prod[11:6];
            end
            else
            begin
                prod    = 12'(c) * 12'(inten);
                tint_ch = prod[11:6];
            end
        end
    endfunction

    logic          valid_reg;
    pep_pkg::rgb_t data_reg;
    pep_pkg::rgb_t data_next;
    logic          health_on;
    logic          shield_on;
    logic          flash_on;
    logic          tint_on;
    logic [5:0]    level;
    logic [5:0]    intensity;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // level select with health over shield over flash
    always_comb
    begin
        health_on = cfg.health_level != 6'd0;
        shield_on = !health_on && (cfg.shield_level != 6'd0);
        flash_on  = !health_on && !shield_on && (cfg.flash_level != 6'd0);
        tint_on   = cfg.fx_enable && (health_on || shield_on || flash_on);
        if (health_on)
            level = cfg.health_level;
        else if (shield_on)
            level = cfg.shield_level;
        else
            level = cfg.flash_level;
        intensity = pep_pkg::CH_MAX - level;
        data_next = up_data;
        if (tint_on)
        begin
            data_next.r = tint_ch(up_data.r, intensity, health_on);
            data_next.g = tint_ch(up_data.g, intensity, shield_on);
            data_next.b = tint_ch(up_data.b, intensity, flash_on);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

/* src/pep_bright.sv */
`timescale 1ns / 1ps
`default_nettype none

module pep_bright (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pep_pkg::cfg_t cfg,
    input  wire logic         up_valid,
    output logic              up_ready,
    input  wire pep_pkg::rgb_t up_data,
    output logic              down_valid,
    input  wire logic         down_ready,
    output pep_pkg::rgb_t     down_data
);

    // (c * b + half) >> 16, b below one so 16 bits suffice
    function automatic logic [5:0] scale_ch(input logic [5:0]  c,
                                            input logic [15:0] b);
        logic [21:0] prod;
        begin
            prod     = 22'(c) * 22'(b) + pep_pkg::BRIGHT_HALF;
            scale_ch = prod[21:16];
        end
    endfunction

    logic          valid_reg;
    pep_pkg::rgb_t data_reg;
    pep_pkg::rgb_t data_next;
    logic          bright_on;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    // brightness applies only when enabled and below unity
    always_comb
    begin
        bright_on = cfg.bright_enable && !cfg.brightness[pep_pkg::BRIGHT_W-1];
        data_next = up_data;
        if (bright_on)
        begin
            data_next.r = scale_ch(up_data.r, cfg.brightness[15:0]);
            data_next.g = scale_ch(up_data.g, cfg.brightness[15:0]);
            data_next.b = scale_ch(up_data.b, cfg.brightness[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire
